/* design/assert_macros.svh */
// Assertion macros shared by the answer builder RTL.
// Included by the modules that carry concurrent checks; empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked while out of reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication, checked while out of reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* design/cdab_pkg.sv */
// Shared types, constants and byte tables for the DNS answer builder.
// No dependencies; used by every module of the block.
package cdab_pkg;

    localparam int MAX_PACKET_DEF = 512;
    localparam int HEADER_LEN     = 12;
    localparam int ANSWER_LEN     = 16;
    localparam int MAX_RESULTS    = 30;
    localparam int LEN_W          = 10;
    localparam int IDX_W          = 9;
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int STEP_W         = $clog2(MAX_RESULTS + 1);
    localparam logic [31:0] ADDR_RESET = 32'hC0A8_0401;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_SEND  = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam logic [7:0] FLAGS_HI = 8'h81;
    localparam logic [7:0] FLAGS_LO = 8'h80;

    // Work unit handed from the parser to the result generator.
    typedef struct packed {
        logic             has_write;
        logic [IDX_W-1:0] widx;
        logic [7:0]       wval;
        logic             has_end;
        logic             drop;
        logic             is_a;
        logic [15:0]      qid;
        logic [15:0]      qcnt;
        logic [LEN_W-1:0] qend;
    } t_cmd;

    // Fixed part of the type A answer: pointer, type, class, TTL, length.
    function automatic logic [7:0] answer_head(input logic [3:0] k);
        logic [7:0] v;
        case (k)
            4'd0:    v = 8'hC0;
            4'd1:    v = 8'h0C;
            4'd3:    v = 8'h01;
            4'd5:    v = 8'h01;
            4'd9:    v = 8'h3C;
            4'd11:   v = 8'h04;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

/* design/cdab_front.sv */
// Request parser: walks header, question name and type/class tail per byte.
// Depends on cdab_pkg; pushes commands into the queue.
module cdab_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic [7:0]      i_byte,
    input  logic            i_last,
    output logic            o_ready,
    input  logic            i_q_full,
    output logic            o_push,
    output cdab_pkg::t_cmd  o_cmd
);

    localparam int MAX_PACKET = cdab_pkg::MAX_PACKET_DEF;
    localparam int POS_W = $clog2(MAX_PACKET + 1);
    localparam int QE_W  = $clog2(MAX_PACKET + 21);

    typedef enum logic [1:0] {PH_HEADER, PH_NAME, PH_TAIL, PH_DONE} t_phase;

    t_phase            r_phase, n_phase;
    logic [15:0]       r_qid, n_qid;
    logic [15:0]       r_qcnt, n_qcnt;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [7:0]        r_lab, n_lab;
    logic [15:0]       r_qtype, n_qtype;
    logic [QE_W-1:0]   r_qend, n_qend;

    logic              accept;
    logic              in_range;
    logic [QE_W-1:0]   p_ext;
    logic              wr;
    logic              is_a;
    logic              drop;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign in_range = (r_pos < POS_W'(MAX_PACKET));
    assign p_ext    = QE_W'(r_pos);

    always_comb begin
        n_phase = r_phase;
        n_qid   = r_qid;
        n_qcnt  = r_qcnt;
        n_pos   = r_pos;
        n_lab   = r_lab;
        n_qtype = r_qtype;
        n_qend  = r_qend;
        wr      = 1'b0;
        if (accept && in_range) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_pos == POS_W'(0)) n_qid[15:8] = i_byte;
                    else if (r_pos == POS_W'(1)) n_qid[7:0] = i_byte;
                    else if (r_pos == POS_W'(4)) n_qcnt[15:8] = i_byte;
                    else if (r_pos == POS_W'(5)) n_qcnt[7:0] = i_byte;
                    if (r_pos == POS_W'(cdab_pkg::HEADER_LEN - 1)) begin
                        n_phase = PH_NAME;
                        n_lab   = 8'd0;
                    end
                end
                PH_NAME: begin
                    wr = 1'b1;
                    if (r_lab != 8'd0) begin
                        n_lab = r_lab - 8'd1;
                    end else if (i_byte == 8'd0) begin
                        n_phase = PH_TAIL;
                        n_qend  = p_ext + QE_W'(5);
                    end else begin
                        n_lab = i_byte;
                    end
                end
                PH_TAIL: begin
                    wr = 1'b1;
                    if (p_ext + QE_W'(4) == r_qend) n_qtype[15:8] = i_byte;
                    else if (p_ext + QE_W'(3) == r_qend) n_qtype[7:0] = i_byte;
                    if (p_ext + QE_W'(1) == r_qend) n_phase = PH_DONE;
                end
                default: ;
            endcase
            n_pos = r_pos + POS_W'(1);
        end
    end

    assign is_a = (n_qtype == 16'd1);
    assign drop = (n_phase != PH_DONE) || (n_qcnt == 16'd0) ||
                  (is_a && (n_qend + QE_W'(cdab_pkg::ANSWER_LEN) > QE_W'(MAX_PACKET)));

    always_comb begin
        o_cmd.has_write = wr;
        o_cmd.widx      = cdab_pkg::IDX_W'(r_pos);
        o_cmd.wval      = i_byte;
        o_cmd.has_end   = i_last;
        o_cmd.drop      = drop;
        o_cmd.is_a      = is_a;
        o_cmd.qid       = n_qid;
        o_cmd.qcnt      = n_qcnt;
        o_cmd.qend      = cdab_pkg::LEN_W'(n_qend);
    end

    assign o_push = accept && (wr || i_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (accept && i_last)) begin
            // Final byte returns the parser to its idle header state.
            r_phase <= PH_HEADER;
            r_qid   <= '0;
            r_qcnt  <= '0;
            r_pos   <= '0;
            r_lab   <= '0;
            r_qtype <= '0;
            r_qend  <= '0;
        end else begin
            r_phase <= n_phase;
            r_qid   <= n_qid;
            r_qcnt  <= n_qcnt;
            r_pos   <= n_pos;
            r_lab   <= n_lab;
            r_qtype <= n_qtype;
            r_qend  <= n_qend;
        end
    end

endmodule

/* design/cdab_fifo.sv */
// Small command queue between the parser and the result generator.
// Depends on cdab_pkg for the command type and depth.
`include "assert_macros.svh"
module cdab_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cdab_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output cdab_pkg::t_cmd  o_cmd
);

    localparam int CNT_W = $clog2(cdab_pkg::QUEUE_DEPTH + 1);

    cdab_pkg::t_cmd                  r_mem [cdab_pkg::QUEUE_DEPTH];
    logic [cdab_pkg::QPTR_W-1:0]     r_wptr;
    logic [cdab_pkg::QPTR_W-1:0]     r_rptr;
    logic [CNT_W-1:0]                r_count;

    assign o_full  = (r_count == CNT_W'(cdab_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != CNT_W'(0));
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_cmd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + cdab_pkg::QPTR_W'(1);
            if (i_pop)  r_rptr <= r_rptr + cdab_pkg::QPTR_W'(1);
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, i_push, !o_full)
    `ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid)
    `ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(cdab_pkg::QUEUE_DEPTH))

endmodule

/* design/cdab_back.sv */
// Result generator: expands each command into write, send or drop results.
// Depends on cdab_pkg; drives the registered result stream.
`include "assert_macros.svh"
module cdab_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    input  cdab_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    input  logic [31:0]                 i_addr,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_kind,
    output logic [cdab_pkg::IDX_W-1:0]  o_idx,
    output logic [7:0]                  o_val,
    output logic [cdab_pkg::LEN_W-1:0]  o_len,
    output logic                        o_last
);

    localparam int SW = cdab_pkg::STEP_W;

    logic [SW-1:0]               r_step;
    logic                        r_valid;
    logic [1:0]                  r_kind;
    logic [cdab_pkg::IDX_W-1:0]  r_idx;
    logic [7:0]                  r_val;
    logic [cdab_pkg::LEN_W-1:0]  r_len;
    logic                        r_last;

    logic                        advance;
    logic                        load;
    logic [SW-1:0]               j;
    logic [SW-1:0]               k;
    logic [SW-1:0]               total;
    logic [1:0]                  it_kind;
    logic [cdab_pkg::IDX_W-1:0]  it_idx;
    logic [7:0]                  it_val;
    logic [cdab_pkg::LEN_W-1:0]  it_len;
    logic                        it_last;

    assign advance = !r_valid || i_ready;
    assign load    = advance && i_cmd_valid;
    assign o_pop   = load && it_last;

    assign j = r_step - SW'(i_cmd.has_write);
    assign k = j - SW'(cdab_pkg::HEADER_LEN);

    always_comb begin
        total = SW'(i_cmd.has_write);
        if (i_cmd.has_end) begin
            if (i_cmd.drop) total = total + SW'(1);
            else if (i_cmd.is_a)
                total = total + SW'(cdab_pkg::HEADER_LEN + cdab_pkg::ANSWER_LEN + 1);
            else total = total + SW'(cdab_pkg::HEADER_LEN + 1);
        end
    end

    assign it_last = (r_step == total - SW'(1));

    always_comb begin
        it_kind = cdab_pkg::KIND_WRITE;
        it_idx  = '0;
        it_val  = '0;
        it_len  = '0;
        if (i_cmd.has_write && r_step == SW'(0)) begin
            it_idx = i_cmd.widx;
            it_val = i_cmd.wval;
        end else if (i_cmd.drop) begin
            it_kind = cdab_pkg::KIND_DROP;
        end else if (j < SW'(cdab_pkg::HEADER_LEN)) begin
            it_idx = cdab_pkg::IDX_W'(j);
            case (j[3:0])
                4'd0:    it_val = i_cmd.qid[15:8];
                4'd1:    it_val = i_cmd.qid[7:0];
                4'd2:    it_val = cdab_pkg::FLAGS_HI;
                4'd3:    it_val = cdab_pkg::FLAGS_LO;
                4'd4:    it_val = i_cmd.qcnt[15:8];
                4'd5:    it_val = i_cmd.qcnt[7:0];
                4'd7:    it_val = {7'd0, i_cmd.is_a};
                default: it_val = 8'd0;
            endcase
        end else if (i_cmd.is_a && k < SW'(cdab_pkg::ANSWER_LEN)) begin
            it_idx = i_cmd.qend[cdab_pkg::IDX_W-1:0] + cdab_pkg::IDX_W'(k);
            if (k < SW'(12)) begin
                it_val = cdab_pkg::answer_head(k[3:0]);
            end else begin
                // Address goes out most significant byte first.
                case (k[1:0])
                    2'd0:    it_val = i_addr[31:24];
                    2'd1:    it_val = i_addr[23:16];
                    2'd2:    it_val = i_addr[15:8];
                    default: it_val = i_addr[7:0];
                endcase
            end
        end else begin
            it_kind = cdab_pkg::KIND_SEND;
            it_len  = i_cmd.is_a ? i_cmd.qend + cdab_pkg::LEN_W'(cdab_pkg::ANSWER_LEN)
                                 : i_cmd.qend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_step  <= '0;
        end else if (advance) begin
            r_valid <= i_cmd_valid;
            if (load) r_step <= it_last ? SW'(0) : r_step + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= it_kind;
            r_idx  <= it_idx;
            r_val  <= it_val;
            r_len  <= it_len;
            r_last <= it_last;
        end
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_idx   = r_idx;
    assign o_val   = r_val;
    assign o_len   = r_len;
    assign o_last  = r_last;

    `ASSERT_SAME(a_step_bound, i_clk, i_rst_n, 1'b1, r_step < SW'(cdab_pkg::MAX_RESULTS))
    `ASSERT_SAME(a_step_has_cmd, i_clk, i_rst_n, r_step != SW'(0), i_cmd_valid)
    `ASSERT_NEXT(a_step_restart, i_clk, i_rst_n, o_pop, r_step == SW'(0) && r_last)

endmodule

/* design/captive_dns_answer_builder.sv */
// Top level of the captive-portal DNS answer builder.
// Depends on cdab_pkg, cdab_front, cdab_fifo and cdab_back.
//
// Takes one DNS request byte per cycle on the slave stream; tlast marks the
// final byte. Question bytes come out as response writes as they arrive,
// passing through the command queue and the registered result stage. The
// final byte produces the header writes, the type A answer writes and a send
// result (up to 30 results), or a single drop result; the result generator
// emits one result per cycle while the output stream is ready. A four-entry
// command queue between the parser and the generator keeps input flowing
// during the result burst; the input stalls only when that queue is full.
// Bytes past the first 512 of a request are ignored. The user must write the
// answer address over the config channel only while the block is idle; the
// block itself does not enforce this, and takes the address every cycle.
module captive_dns_answer_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [8:0] byte_index, [16:9] byte_value,
                                        // [26:17] send_length, [31:27] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] result_kind
    output logic        m_axis_tlast,   // run_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data      // answer_address
);

    cdab_pkg::t_cmd                   push_cmd;
    cdab_pkg::t_cmd                   head_cmd;
    logic                             push;
    logic                             pop;
    logic                             q_full;
    logic                             q_valid;
    logic [31:0]                      r_addr;
    logic [cdab_pkg::IDX_W-1:0]       res_idx;
    logic [7:0]                       res_val;
    logic [cdab_pkg::LEN_W-1:0]       res_len;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= cdab_pkg::ADDR_RESET;
        end else if (i_cfg_valid) begin
            r_addr <= i_cfg_data;
        end
    end

    cdab_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .i_byte   (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .o_ready  (s_axis_tready),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    cdab_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (head_cmd)
    );

    cdab_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (head_cmd),
        .o_pop       (pop),
        .i_addr      (r_addr),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_kind      (m_axis_tuser),
        .o_idx       (res_idx),
        .o_val       (res_val),
        .o_len       (res_len),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, res_len, res_val, res_idx};

endmodule
